// ----- rtl/ipv4ck_pkg.sv -----
// Package for the IPv4 checksum engine: protocol and kind codes, header and
// transport field offsets, and the per-packet summary struct.
// No dependencies.
`default_nettype none

package ipv4ck_pkg;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_TCP  = 2'd1;
    localparam logic [1:0] KIND_UDP  = 2'd2;
    localparam logic [1:0] KIND_ICMP = 2'd3;

    localparam logic [15:0] OFF_IHL        = 16'd0;
    localparam logic [15:0] OFF_TOTLEN_LO  = 16'd3;
    localparam logic [15:0] OFF_PROTO      = 16'd9;
    localparam logic [15:0] OFF_HCK_HI     = 16'd10;
    localparam logic [15:0] OFF_HCK_LO     = 16'd11;
    localparam logic [15:0] OFF_SRC_ADDR   = 16'd12;
    localparam logic [15:0] OFF_ADDR_END   = 16'd20;

    localparam logic [15:0] L4_UDP_LEN_LO  = 16'd5;
    localparam logic [15:0] L4_UDP_CK_HI   = 16'd6;
    localparam logic [15:0] L4_UDP_CK_LO   = 16'd7;
    localparam logic [15:0] L4_TCP_DOFF    = 16'd12;
    localparam logic [15:0] L4_TCP_CK_HI   = 16'd16;
    localparam logic [15:0] L4_TCP_CK_LO   = 16'd17;
    localparam logic [15:0] L4_ICMP_CK_HI  = 16'd2;
    localparam logic [15:0] L4_ICMP_CK_LO  = 16'd3;

    localparam logic [3:0]  MIN_IHL        = 4'd5;
    localparam logic [15:0] MIN_HDR_BYTES  = 16'd20;

    typedef struct packed {
        logic [3:0]  header_words;
        logic [15:0] total_length;
        logic [7:0]  protocol;
        logic [15:0] stored_sum;
        logic [20:0] header_acc;
        logic [31:0] transport_acc;
        logic [15:0] udp_length;
        logic [3:0]  tcp_offset;
        logic        want_l4;
        logic [15:0] buf_length;
    } t_pkt_sums;

endpackage

`default_nettype wire

// ----- rtl/ipv4ck_accum.sv -----
// Byte stage of the IPv4 checksum engine: input register, per-byte field
// capture and running sums, and the end-of-packet summary register.
// Depends on ipv4ck_pkg.
`default_nettype none

module ipv4ck_accum
    import ipv4ck_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_compute_l4,
    output logic        o_sum_valid,
    output t_pkt_sums   o_sums,
    input  logic        i_sum_free
);

    localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);
    localparam logic [OFF_W-1:0] OFF_LIMIT = OFF_W'(MAX_PACKET_BYTES);

    logic             r_in_valid;
    logic [7:0]       r_in_data;
    logic             r_in_last;
    logic             r_in_req;

    logic [OFF_W-1:0] r_off,    n_off;
    logic [3:0]       r_hw,     n_hw;
    logic [15:0]      r_tl,     n_tl;
    logic [7:0]       r_proto,  n_proto;
    logic [15:0]      r_stored, n_stored;
    logic [20:0]      r_hacc,   n_hacc;
    logic [31:0]      r_tacc,   n_tacc;
    logic [7:0]       r_pend,   n_pend;
    logic [15:0]      r_udp,    n_udp;
    logic [3:0]       r_tcp,    n_tcp;
    logic             r_want,   n_want;

    logic             r_sum_valid;
    t_pkt_sums        r_sums;

    logic [15:0]      off16;
    logic [15:0]      hl16;
    logic [15:0]      rel;
    logic [15:0]      part;
    logic             is_ck;
    logic             sum_slot_free;
    logic             go;
    logic             in_take;

    assign off16 = 16'(r_off);
    assign part  = r_off[0] ? {8'h00, r_in_data} : {r_in_data, 8'h00};

    always_comb begin
        n_off    = r_off;
        n_hw     = r_hw;
        n_tl     = r_tl;
        n_proto  = r_proto;
        n_stored = r_stored;
        n_hacc   = r_hacc;
        n_tacc   = r_tacc;
        n_pend   = r_pend;
        n_udp    = r_udp;
        n_tcp    = r_tcp;
        n_want   = r_want;
        hl16     = {10'd0, r_hw, 2'b00};
        rel      = '0;
        is_ck    = 1'b0;
        if (r_off < OFF_LIMIT) begin
            n_off = r_off + 1'b1;
            if (off16 == OFF_IHL) begin
                n_want = r_in_req;
                n_hw   = r_in_data[3:0];
            end
            hl16 = {10'd0, n_hw, 2'b00};
            if (off16 < hl16 && off16 != OFF_HCK_HI && off16 != OFF_HCK_LO)
                n_hacc = r_hacc + 21'(part);
            if (off16 == OFF_TOTLEN_LO)
                n_tl = {r_pend, r_in_data};
            if (off16 == OFF_PROTO)
                n_proto = r_in_data;
            if (off16 == OFF_HCK_LO)
                n_stored = {r_pend, r_in_data};
            if (off16 >= OFF_SRC_ADDR && off16 < OFF_ADDR_END &&
                (n_proto == PROTO_TCP || n_proto == PROTO_UDP))
                n_tacc = r_tacc + 32'(part);
            if (n_hw >= MIN_IHL && off16 >= hl16) begin
                rel   = off16 - hl16;
                is_ck = (n_proto == PROTO_TCP  && (rel == L4_TCP_CK_HI  || rel == L4_TCP_CK_LO))
                     || (n_proto == PROTO_UDP  && (rel == L4_UDP_CK_HI  || rel == L4_UDP_CK_LO))
                     || (n_proto == PROTO_ICMP && (rel == L4_ICMP_CK_HI || rel == L4_ICMP_CK_LO));
                if (rel == L4_UDP_LEN_LO)
                    n_udp = {r_pend, r_in_data};
                if (rel == L4_TCP_DOFF)
                    n_tcp = r_in_data[7:4];
                if (off16 < n_tl && !is_ck)
                    n_tacc = r_tacc + 32'(part);
            end
            n_pend = r_in_data;
        end
    end

    assign sum_slot_free = !r_sum_valid || i_sum_free;
    assign go            = r_in_valid && (!r_in_last || sum_slot_free);
    assign o_stall       = r_in_valid && !go;
    assign in_take       = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_data_byte;
            r_in_last <= i_last_byte;
            r_in_req  <= i_compute_l4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (go && r_in_last)) begin
            r_off    <= '0;
            r_hw     <= '0;
            r_tl     <= '0;
            r_proto  <= '0;
            r_stored <= '0;
            r_hacc   <= '0;
            r_tacc   <= '0;
            r_pend   <= '0;
            r_udp    <= '0;
            r_tcp    <= '0;
            r_want   <= 1'b0;
        end else if (go) begin
            r_off    <= n_off;
            r_hw     <= n_hw;
            r_tl     <= n_tl;
            r_proto  <= n_proto;
            r_stored <= n_stored;
            r_hacc   <= n_hacc;
            r_tacc   <= n_tacc;
            r_pend   <= n_pend;
            r_udp    <= n_udp;
            r_tcp    <= n_tcp;
            r_want   <= n_want;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid <= 1'b0;
        end else if (go && r_in_last) begin
            r_sum_valid <= 1'b1;
        end else if (i_sum_free) begin
            r_sum_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && r_in_last) begin
            r_sums.header_words  <= n_hw;
            r_sums.total_length  <= n_tl;
            r_sums.protocol      <= n_proto;
            r_sums.stored_sum    <= n_stored;
            r_sums.header_acc    <= n_hacc;
            r_sums.transport_acc <= n_tacc;
            r_sums.udp_length    <= n_udp;
            r_sums.tcp_offset    <= n_tcp;
            r_sums.want_l4       <= n_want;
            r_sums.buf_length    <= 16'(n_off);
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_sums      = r_sums;

endmodule

`default_nettype wire

// ----- rtl/ipv4ck_finish.sv -----
// Result stage of the IPv4 checksum engine: folds and inverts the sums,
// runs the length checks and holds the result item for the receiver.
// Depends on ipv4ck_pkg.
`default_nettype none

module ipv4ck_finish
    import ipv4ck_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_sum_valid,
    input  t_pkt_sums   i_sums,
    output logic        o_sum_free,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_ip_checksum,
    output logic [15:0] o_l4_checksum,
    output logic [1:0]  o_l4_kind,
    output logic        o_header_match,
    output logic        o_length_ok,
    output logic        o_packet_valid
);

    logic        r_out_valid;
    logic [15:0] r_ip_ck;
    logic [15:0] r_l4_ck;
    logic [1:0]  r_kind;
    logic        r_match;
    logic        r_len_ok;

    logic [15:0] hl16;
    logic [15:0] l4len;
    logic [16:0] hs1;
    logic [16:0] hs2;
    logic [15:0] ip_ck;
    logic [1:0]  kind;
    logic [16:0] pseudo;
    logic [32:0] ts;
    logic [17:0] f1;
    logic [16:0] f2;
    logic [15:0] f3;
    logic [15:0] l4_ck;
    logic [15:0] tcp_end;
    logic        len_ok;
    logic        out_free;

    assign hl16  = {10'd0, i_sums.header_words, 2'b00};
    assign l4len = i_sums.total_length - hl16;

    assign hs1   = {1'b0, i_sums.header_acc[15:0]} + 17'(i_sums.header_acc[20:16]);
    assign hs2   = {1'b0, hs1[15:0]} + 17'(hs1[16]);
    assign ip_ck = ~hs2[15:0];

    always_comb begin
        kind = KIND_NONE;
        if (i_sums.want_l4 && i_sums.header_words >= MIN_IHL) begin
            case (i_sums.protocol)
                PROTO_TCP:  kind = KIND_TCP;
                PROTO_UDP:  kind = KIND_UDP;
                PROTO_ICMP: kind = KIND_ICMP;
                default:    kind = KIND_NONE;
            endcase
        end
    end

    assign pseudo = (kind == KIND_TCP || kind == KIND_UDP)
                  ? 17'(i_sums.protocol) + 17'(l4len) : 17'd0;
    assign ts     = {1'b0, i_sums.transport_acc} + 33'(pseudo);
    assign f1     = 18'(ts[15:0]) + 18'(ts[32:16]);
    assign f2     = 17'(f1[15:0]) + 17'(f1[17:16]);
    assign f3     = f2[15:0] + 16'(f2[16]);
    assign l4_ck  = (kind == KIND_NONE) ? 16'd0 : ~f3;

    assign tcp_end = hl16 + {10'd0, i_sums.tcp_offset, 2'b00};

    always_comb begin
        len_ok = 1'b1;
        if (i_sums.header_words < MIN_IHL || i_sums.buf_length < MIN_HDR_BYTES ||
            i_sums.buf_length < hl16)
            len_ok = 1'b0;
        if (i_sums.total_length > i_sums.buf_length)
            len_ok = 1'b0;
        if (i_sums.protocol == PROTO_UDP && l4len != i_sums.udp_length)
            len_ok = 1'b0;
        if (i_sums.protocol == PROTO_TCP && tcp_end > i_sums.total_length)
            len_ok = 1'b0;
    end

    assign out_free   = !r_out_valid || !i_stall;
    assign o_sum_free = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= i_sum_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && i_sum_valid) begin
            r_ip_ck  <= ip_ck;
            r_l4_ck  <= l4_ck;
            r_kind   <= kind;
            r_match  <= (ip_ck == i_sums.stored_sum);
            r_len_ok <= len_ok;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_ip_checksum  = r_ip_ck;
    assign o_l4_checksum  = r_l4_ck;
    assign o_l4_kind      = r_kind;
    assign o_header_match = r_match;
    assign o_length_ok    = r_len_ok;
    assign o_packet_valid = r_match && r_len_ok;

endmodule

`default_nettype wire

// ----- rtl/ipv4_packet_checksum_engine.sv -----
// IPv4 checksum engine top level: byte stage followed by result stage.
// Depends on ipv4ck_pkg, ipv4ck_accum and ipv4ck_finish.
//
// Input channel (i_valid / o_stall): one packet byte per item, first byte
// being the first IPv4 header byte; i_last_byte ends the packet and
// i_compute_l4 is sampled with the first byte.
// Output channel (o_valid / i_stall): one result item per packet, carrying
// both checksums, the transport kind and the header and length checks.
// Throughput: one byte per cycle while o_stall is low; packets may follow back
// to back, the first byte of the next packet directly after the last of the
// previous. After the last byte is accepted, the result passes the input
// register, then the summary register, then the result register.
// Bytes past MAX_PACKET_BYTES are ignored but a last flag among them still
// closes the packet.
// Reset (synchronous, active low) empties all stages and clears the running
// sums. While the receiver stalls, the result is held; bytes keep flowing
// until the last byte of a packet finds the summary register still full,
// at which point o_stall rises.
`default_nettype none

module ipv4_packet_checksum_engine
    import ipv4ck_pkg::*;
#(
    parameter int MAX_PACKET_BYTES = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic        i_compute_l4,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_ip_checksum,
    output logic [15:0] o_l4_checksum,
    output logic [1:0]  o_l4_kind,
    output logic        o_header_match,
    output logic        o_length_ok,
    output logic        o_packet_valid
);

    logic      sum_valid;
    logic      sum_free;
    t_pkt_sums sums;

    ipv4ck_accum #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_compute_l4 (i_compute_l4),
        .o_sum_valid  (sum_valid),
        .o_sums       (sums),
        .i_sum_free   (sum_free)
    );

    ipv4ck_finish u_finish (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_sum_valid    (sum_valid),
        .i_sums         (sums),
        .o_sum_free     (sum_free),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_ip_checksum  (o_ip_checksum),
        .o_l4_checksum  (o_l4_checksum),
        .o_l4_kind      (o_l4_kind),
        .o_header_match (o_header_match),
        .o_length_ok    (o_length_ok),
        .o_packet_valid (o_packet_valid)
    );

endmodule

`default_nettype wire
